// ===== src/ehp_pkg.sv =====
// Constants and result layout for the Ethernet / IPv4 / L4 header parser.
// No dependencies; imported by eth_ipv4_l4_header_parser_core.
package ehp_pkg;

   localparam int unsigned EtherAddrLen = 6;
   localparam int unsigned EthHdrLen    = 14;
   localparam int unsigned PosWidth     = 7;
   localparam int unsigned RspDataWidth = 240;

   localparam logic [PosWidth-1:0] POS_MAX      = 7'd127;
   localparam logic [PosWidth-1:0] POS_IHL      = 7'd14;
   localparam logic [PosWidth-1:0] POS_TTL      = 7'd22;
   localparam logic [PosWidth-1:0] POS_PROTO    = 7'd23;
   localparam logic [PosWidth-1:0] POS_SRC_ADDR = 7'd26;
   localparam logic [PosWidth-1:0] POS_DST_ADDR = 7'd30;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [2:0] CLASS_NON_IP    = 3'd0;
   localparam logic [2:0] CLASS_TCP       = 3'd1;
   localparam logic [2:0] CLASS_UDP       = 3'd2;
   localparam logic [2:0] CLASS_OTHER_L4  = 3'd3;
   localparam logic [2:0] CLASS_TRUNCATED = 3'd4;

   // rsp_tdata layout, lowest bits last in this list
   typedef struct packed {
      logic [1:0]  pad;
      logic [7:0]  tcp_flag_bits;
      logic [15:0] l4_dst_port;
      logic [15:0] l4_src_port;
      logic [31:0] ip_dst_addr;
      logic [31:0] ip_src_addr;
      logic [7:0]  ip_proto;
      logic [7:0]  ip_ttl;
      logic [5:0]  ip_hdr_bytes;
      logic [15:0] eth_type;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
   } rsp_data_type;

endpackage

// ===== src/eth_ipv4_l4_header_parser_core.sv =====
// Ethernet / IPv4 / TCP-UDP header parser: byte stream in, one summary beat per frame.
// Depends on ehp_pkg.
//
//  channel | dir | beat
//  req     | in  | tdata[7:0] data byte, tlast frame end
//  rsp     | out | tdata[239:0] header summary, tuser[2:0] packet class
//
// One byte per cycle while req_tready is high; the summary is registered on the last byte.
// The result register frees in the same cycle it is taken, so a held rsp only stalls req
// while rsp_tready is low. Reset is synchronous and clears the parser and result valid.
module eth_ipv4_l4_header_parser_core
   import ehp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   input  logic                    req_tlast,   // last_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // dst_mac, src_mac, eth_type, ip_hdr_bytes,
                                                // ip_ttl, ip_proto, ip_src_addr, ip_dst_addr,
                                                // l4_src_port, l4_dst_port, tcp_flag_bits, pad
   output logic [2:0]              rsp_tuser    // packet_class
);

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [47:0] dst_mac_ff, dst_mac_in;
   logic [47:0] src_mac_ff, src_mac_in;
   logic [15:0] eth_type_ff, eth_type_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_addr_ff, src_addr_in;
   logic [31:0] dst_addr_ff, dst_addr_in;
   logic [15:0] src_port_ff, src_port_in;
   logic [15:0] dst_port_ff, dst_port_in;
   logic [7:0]  flags_ff, flags_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic [2:0]   rsp_class_ff, rsp_class_in;

   logic       accept;
   logic [6:0] l4_pos;
   logic [7:0] n_bytes;
   logic       is_ip, proto_known, is_tcp, is_udp;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // field capture by byte position
   always_comb begin
      ihl_in        = ihl_ff;
      dst_mac_in    = dst_mac_ff;
      src_mac_in    = src_mac_ff;
      eth_type_in   = eth_type_ff;
      ttl_in        = ttl_ff;
      proto_in      = proto_ff;
      src_addr_in   = src_addr_ff;
      dst_addr_in   = dst_addr_ff;
      src_port_in   = src_port_ff;
      dst_port_in   = dst_port_ff;
      flags_in      = flags_ff;

      if (pos_ff == POS_IHL) begin
         ihl_in = req_tdata[3:0];
      end
      l4_pos = 7'(EthHdrLen) + {1'b0, ihl_in, 2'b00};

      for (int i = 0; i < EtherAddrLen; i++) begin
         if (pos_ff == 7'(i)) begin
            dst_mac_in[8*(EtherAddrLen-1-i) +: 8] = req_tdata;
         end
         if (pos_ff == 7'(EtherAddrLen + i)) begin
            src_mac_in[8*(EtherAddrLen-1-i) +: 8] = req_tdata;
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (pos_ff == 7'(2*EtherAddrLen + i)) begin
            eth_type_in[8*(1-i) +: 8] = req_tdata;
         end
         if (pos_ff == l4_pos + 7'(i)) begin
            src_port_in[8*(1-i) +: 8] = req_tdata;
         end
         if (pos_ff == l4_pos + 7'(2 + i)) begin
            dst_port_in[8*(1-i) +: 8] = req_tdata;
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (pos_ff == POS_SRC_ADDR + 7'(i)) begin
            src_addr_in[8*(3-i) +: 8] = req_tdata;
         end
         if (pos_ff == POS_DST_ADDR + 7'(i)) begin
            dst_addr_in[8*(3-i) +: 8] = req_tdata;
         end
      end
      if (pos_ff == POS_TTL) begin
         ttl_in = req_tdata;
      end
      if (pos_ff == POS_PROTO) begin
         proto_in = req_tdata;
      end
      if (pos_ff == l4_pos + 7'd13) begin
         flags_in = req_tdata;
      end

      pos_in = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : POS_MAX;
   end

   // summary for a frame ending on this beat
   always_comb begin
      n_bytes     = {1'b0, pos_ff} + 8'd1;
      is_ip       = (n_bytes >= 8'(EthHdrLen)) && (eth_type_in == ETHERTYPE_IPV4);
      proto_known = is_ip && (n_bytes >= 8'(EthHdrLen + 10));
      is_tcp      = proto_known && (proto_in == PROTO_TCP);
      is_udp      = proto_known && (proto_in == PROTO_UDP);

      if (n_bytes < 8'(EthHdrLen)) begin
         rsp_class_in = CLASS_TRUNCATED;
      end else if (!is_ip) begin
         rsp_class_in = CLASS_NON_IP;
      end else if (n_bytes < 8'(EthHdrLen + 20)) begin
         rsp_class_in = CLASS_TRUNCATED;
      end else if (is_tcp) begin
         rsp_class_in = (n_bytes >= {1'b0, l4_pos} + 8'd14) ? CLASS_TCP : CLASS_TRUNCATED;
      end else if (is_udp) begin
         rsp_class_in = (n_bytes >= {1'b0, l4_pos} + 8'd4) ? CLASS_UDP : CLASS_TRUNCATED;
      end else begin
         rsp_class_in = CLASS_OTHER_L4;
      end

      rsp_data_in               = '0;
      rsp_data_in.dst_mac       = dst_mac_in;
      rsp_data_in.src_mac       = src_mac_in;
      rsp_data_in.eth_type      = eth_type_in;
      rsp_data_in.ip_hdr_bytes  = is_ip ? {ihl_in, 2'b00} : 6'd0;
      rsp_data_in.ip_ttl        = is_ip ? ttl_in : 8'd0;
      rsp_data_in.ip_proto      = is_ip ? proto_in : 8'd0;
      rsp_data_in.ip_src_addr   = is_ip ? src_addr_in : 32'd0;
      rsp_data_in.ip_dst_addr   = is_ip ? dst_addr_in : 32'd0;
      rsp_data_in.l4_src_port   = (is_tcp || is_udp) ? src_port_in : 16'd0;
      rsp_data_in.l4_dst_port   = (is_tcp || is_udp) ? dst_port_in : 16'd0;
      rsp_data_in.tcp_flag_bits = is_tcp ? flags_in : 8'd0;

      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         pos_ff        <= '0;
         dst_mac_ff    <= '0;
         src_mac_ff    <= '0;
         eth_type_ff   <= '0;
         ihl_ff        <= '0;
         ttl_ff        <= '0;
         proto_ff      <= '0;
         src_addr_ff   <= '0;
         dst_addr_ff   <= '0;
         src_port_ff   <= '0;
         dst_port_ff   <= '0;
         flags_ff      <= '0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         dst_mac_ff    <= dst_mac_in;
         src_mac_ff    <= src_mac_in;
         eth_type_ff   <= eth_type_in;
         ihl_ff        <= ihl_in;
         ttl_ff        <= ttl_in;
         proto_ff      <= proto_in;
         src_addr_ff   <= src_addr_in;
         dst_addr_ff   <= dst_addr_in;
         src_port_ff   <= src_port_in;
         dst_port_ff   <= dst_port_in;
         flags_ff      <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_class_ff <= rsp_class_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_class_ff;

endmodule
